// File: rtl/bpsa_pkg.sv
// Package for the battery pack status aggregator.
// Field widths, fixed-point constants, sequencer state and store entry types.
// No dependencies.
package bpsa_pkg;

   localparam int FIELD_W   = 20;
   localparam int IN_CUR_W  = 21;
   localparam int VOLT_W    = 16;
   localparam int SUM_W     = 24;
   localparam int CUR_W     = 25;
   localparam int RATE_W    = 24;
   localparam int FRAC_W    = 16;
   localparam int RATE_NUM_W = FIELD_W + FRAC_W;
   localparam int PROD_W    = FIELD_W + RATE_W;
   localparam int CE_W      = PROD_W - FRAC_W;
   localparam int POW_W     = CE_W + VOLT_W;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DIVC  = 11'b000_0000_0010,
      ST_DIVD  = 11'b000_0000_0100,
      ST_UPD   = 11'b000_0000_1000,
      ST_WRD   = 11'b000_0001_0000,
      ST_WM1   = 11'b000_0010_0000,
      ST_WM2   = 11'b000_0100_0000,
      ST_WACC  = 11'b000_1000_0000,
      ST_VDIV  = 11'b001_0000_0000,
      ST_VWAIT = 11'b010_0000_0000,
      ST_FIN   = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] room;
      logic [FIELD_W-1:0] charge;
      logic [VOLT_W-1:0]  volt;
   } entry_type;

endpackage

// File: rtl/bpsa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Numerator is MSB aligned; quotient kept to 24 bits with an overflow flag.
// Depends on bpsa_pkg.
module bpsa_div #(
   parameter int NUMW = 49,
   parameter int DENW = 33,
   parameter int ITW  = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUMW-1:0]              num,
   input  logic [DENW-1:0]              den,
   input  logic [ITW-1:0]               iters,
   output logic                         busy,
   output logic                         done,
   output logic [bpsa_pkg::RATE_W-1:0]  quot,
   output logic                         sat
);
   import bpsa_pkg::*;

   logic [NUMW-1:0]   num_ff;
   logic [DENW-1:0]   den_ff;
   logic [DENW-1:0]   rem_ff;
   logic [DENW-1:0]   rem_in;
   logic [RATE_W-1:0] quot_ff;
   logic              sat_ff;
   logic [ITW-1:0]    cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DENW:0]     trial;
   logic [DENW:0]     diff;
   logic              ge;

   assign trial  = {rem_ff, num_ff[NUMW-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? diff[DENW-1:0] : trial[DENW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == ITW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[NUMW-2:0], 1'b0};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[RATE_W-2:0], ge};
         sat_ff  <= sat_ff | quot_ff[RATE_W-1];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

// File: rtl/battery_pack_status_aggregator.sv
// Battery pack status aggregator: per-cell status in, pack status out.
// Takes one cell item on the req_ channel (valid/ready). Each stored cell costs
// two bit-serial divisions on the shared divider (36 quotient bits of the
// Q20.16 rate numerator, one a cycle, kept as a Q8.16 rate), then the update
// state and a return to idle before the next accept.
// A cell that arrives with the store full is taken without a division.
// An item with last_cell set also starts the pack walk: for each stored entry
// a store read, two registered multiply stages and an accumulate, then a
// check of the totals and one voltage division, then the result is loaded
// into the rsp_ output register.
// At most MAX_CELLS cells are kept per set; later cells are dropped, though a
// last_cell mark on them still closes the set.
// Reset clears the set totals and minima and the sequencer; the entry store
// is not cleared, as only entries of the current set are read.
// A result waiting on rsp_ready does not block new items; only a second
// result waits in the final state until the output register is taken.
// Both limit totals zero: pack_voltage 0 with divide_error set.
// Depends on bpsa_pkg and bpsa_div.
module battery_pack_status_aggregator #(
   parameter int MAX_CELLS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [bpsa_pkg::IN_CUR_W-1:0] req_cell_current,
   input  logic [bpsa_pkg::FIELD_W-1:0]         req_cell_charge,
   input  logic [bpsa_pkg::FIELD_W-1:0]         req_cell_full_charge,
   input  logic [bpsa_pkg::FIELD_W-1:0]         req_cell_charge_limit,
   input  logic [bpsa_pkg::FIELD_W-1:0]         req_cell_discharge_limit,
   input  logic [bpsa_pkg::VOLT_W-1:0]          req_cell_voltage,
   input  logic                                 req_last_cell,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bpsa_pkg::CUR_W-1:0]    rsp_pack_current,
   output logic [bpsa_pkg::SUM_W-1:0]           rsp_pack_charge,
   output logic [bpsa_pkg::SUM_W-1:0]           rsp_pack_full_charge,
   output logic [bpsa_pkg::SUM_W-1:0]           rsp_pack_charge_limit,
   output logic [bpsa_pkg::SUM_W-1:0]           rsp_pack_discharge_limit,
   output logic [bpsa_pkg::VOLT_W-1:0]          rsp_pack_voltage,
   output logic                                 rsp_divide_error
);
   import bpsa_pkg::*;

   localparam int CW   = $clog2(MAX_CELLS + 1);
   localparam int AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int ETW  = CE_W + CW;
   localparam int PW   = POW_W + CW;
   localparam int ITW  = $clog2(PW + 1);

   state_type state_ff;

   entry_type mem [MAX_CELLS];
   entry_type rd_ff;

   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            walk_ff;
   logic                     full_set;
   logic [RATE_W-1:0]        minc_ff;
   logic [RATE_W-1:0]        mind_ff;
   logic [RATE_W-1:0]        crate_ff;
   logic [RATE_W-1:0]        rate_val;
   logic signed [CUR_W-1:0]  cs_ff;
   logic signed [CUR_W:0]    cs_sum;
   logic [SUM_W-1:0]         chs_ff;
   logic [SUM_W-1:0]         fs_ff;
   logic [SUM_W:0]           chs_sum;
   logic [SUM_W:0]           fs_sum;

   logic signed [IN_CUR_W-1:0] cur_ff;
   logic [FIELD_W-1:0]       chg_ff;
   logic [FIELD_W-1:0]       full_ff;
   logic [FIELD_W-1:0]       dlim_ff;
   logic [FIELD_W-1:0]       room_ff;
   logic [VOLT_W-1:0]        volt_ff;
   logic                     last_ff;
   logic [FIELD_W-1:0]       room_c;

   logic [PROD_W-1:0]        pc_ff;
   logic [PROD_W-1:0]        pd_ff;
   logic [VOLT_W-1:0]        vr_ff;
   logic [CE_W-1:0]          ce_ff;
   logic [CE_W-1:0]          de_ff;
   logic [POW_W-1:0]         epc_ff;
   logic [POW_W-1:0]         epd_ff;
   logic [ETW-1:0]           ctot_ff;
   logic [ETW-1:0]           dtot_ff;
   logic [PW-1:0]            cpow_ff;
   logic [PW-1:0]            dpow_ff;
   logic                     tot_zero;

   logic [VOLT_W-1:0]        vout_ff;
   logic                     err_ff;

   logic                     rsp_valid_ff;
   logic signed [CUR_W-1:0]  o_cur_ff;
   logic [SUM_W-1:0]         o_chg_ff;
   logic [SUM_W-1:0]         o_full_ff;
   logic [SUM_W-1:0]         o_clim_ff;
   logic [SUM_W-1:0]         o_dlim_ff;
   logic [VOLT_W-1:0]        o_volt_ff;
   logic                     o_err_ff;

   logic                     div_start;
   logic [PW-1:0]            div_num;
   logic [ETW-1:0]           div_den;
   logic [ITW-1:0]           div_iters;
   logic                     div_busy;
   logic                     div_done;
   logic [RATE_W-1:0]        div_quot;
   logic                     div_sat;
   logic                     req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign full_set  = (count_ff >= CW'(MAX_CELLS));
   assign room_c    = (req_cell_full_charge > req_cell_charge) ?
                      (req_cell_full_charge - req_cell_charge) : '0;
   assign tot_zero  = (ctot_ff == '0) && (dtot_ff == '0);

   always_comb begin
      div_start = 1'b0;
      div_num   = {dpow_ff};
      div_den   = dtot_ff;
      div_iters = ITW'(PW);
      unique case (state_ff)
         ST_IDLE: begin
            div_start = req_fire && !full_set;
            div_num   = {req_cell_charge_limit, {(PW-FIELD_W){1'b0}}};
            div_den   = ETW'(room_c);
            div_iters = ITW'(RATE_NUM_W);
         end
         ST_DIVC: begin
            div_start = div_done;
            div_num   = {dlim_ff, {(PW-FIELD_W){1'b0}}};
            div_den   = ETW'(chg_ff);
            div_iters = ITW'(RATE_NUM_W);
         end
         ST_VDIV: begin
            div_start = !tot_zero;
            if (ctot_ff != '0) begin
               div_num = cpow_ff;
               div_den = ctot_ff;
            end
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_DIVC) begin
         rate_val = (room_ff == '0) ? '0 : (div_sat ? RATE_MAX : div_quot);
      end else begin
         rate_val = (chg_ff == '0) ? '0 : (div_sat ? RATE_MAX : div_quot);
      end
   end

   assign cs_sum  = {cs_ff[CUR_W-1], cs_ff} +
                    {{(CUR_W+1-IN_CUR_W){cur_ff[IN_CUR_W-1]}}, cur_ff};
   assign chs_sum = {1'b0, chs_ff} + (SUM_W+1)'(chg_ff);
   assign fs_sum  = {1'b0, fs_ff} + (SUM_W+1)'(full_ff);

   bpsa_div #(
      .NUMW (PW),
      .DENW (ETW),
      .ITW  (ITW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot),
      .sat   (div_sat)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         mem[count_ff[AW-1:0]] <= '{room: room_ff, charge: chg_ff, volt: volt_ff};
      end
      rd_ff <= mem[walk_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         minc_ff      <= RATE_MAX;
         mind_ff      <= RATE_MAX;
         cs_ff        <= '0;
         chs_ff       <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  cur_ff  <= req_cell_current;
                  chg_ff  <= req_cell_charge;
                  full_ff <= req_cell_full_charge;
                  dlim_ff <= req_cell_discharge_limit;
                  volt_ff <= req_cell_voltage;
                  last_ff <= req_last_cell;
                  room_ff <= room_c;
                  if (!full_set) begin
                     state_ff <= ST_DIVC;
                  end else if (req_last_cell) begin
                     walk_ff  <= '0;
                     ctot_ff  <= '0;
                     dtot_ff  <= '0;
                     cpow_ff  <= '0;
                     dpow_ff  <= '0;
                     state_ff <= ST_WRD;
                  end
               end
            end
            ST_DIVC: begin
               if (div_done) begin
                  crate_ff <= rate_val;
                  state_ff <= ST_DIVD;
               end
            end
            ST_DIVD: begin
               if (div_done) begin
                  if (rate_val < mind_ff) begin
                     mind_ff <= rate_val;
                  end
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               count_ff <= count_ff + 1'b1;
               if (crate_ff < minc_ff) begin
                  minc_ff <= crate_ff;
               end
               if (cs_sum > (CUR_W+1)'(signed'(26'sd16777215))) begin
                  cs_ff <= {1'b0, {(CUR_W-1){1'b1}}};
               end else if (cs_sum < -26'sd16777216) begin
                  cs_ff <= {1'b1, {(CUR_W-1){1'b0}}};
               end else begin
                  cs_ff <= cs_sum[CUR_W-1:0];
               end
               chs_ff <= chs_sum[SUM_W] ? SUM_MAX : chs_sum[SUM_W-1:0];
               fs_ff  <= fs_sum[SUM_W] ? SUM_MAX : fs_sum[SUM_W-1:0];
               if (last_ff) begin
                  walk_ff  <= '0;
                  ctot_ff  <= '0;
                  dtot_ff  <= '0;
                  cpow_ff  <= '0;
                  dpow_ff  <= '0;
                  state_ff <= ST_WRD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WRD: begin
               if (walk_ff == count_ff) begin
                  state_ff <= ST_VDIV;
               end else begin
                  walk_ff  <= walk_ff + 1'b1;
                  state_ff <= ST_WM1;
               end
            end
            ST_WM1: begin
               pc_ff    <= PROD_W'(rd_ff.room) * PROD_W'(minc_ff);
               pd_ff    <= PROD_W'(rd_ff.charge) * PROD_W'(mind_ff);
               vr_ff    <= rd_ff.volt;
               state_ff <= ST_WM2;
            end
            ST_WM2: begin
               ce_ff    <= pc_ff[PROD_W-1:FRAC_W];
               de_ff    <= pd_ff[PROD_W-1:FRAC_W];
               epc_ff   <= POW_W'(pc_ff[PROD_W-1:FRAC_W]) * POW_W'(vr_ff);
               epd_ff   <= POW_W'(pd_ff[PROD_W-1:FRAC_W]) * POW_W'(vr_ff);
               state_ff <= ST_WACC;
            end
            ST_WACC: begin
               ctot_ff  <= ctot_ff + ETW'(ce_ff);
               dtot_ff  <= dtot_ff + ETW'(de_ff);
               cpow_ff  <= cpow_ff + PW'(epc_ff);
               dpow_ff  <= dpow_ff + PW'(epd_ff);
               state_ff <= ST_WRD;
            end
            ST_VDIV: begin
               if (tot_zero) begin
                  err_ff   <= 1'b1;
                  vout_ff  <= '0;
                  state_ff <= ST_FIN;
               end else begin
                  err_ff   <= 1'b0;
                  state_ff <= ST_VWAIT;
               end
            end
            ST_VWAIT: begin
               if (div_done) begin
                  vout_ff  <= (div_sat || (div_quot[RATE_W-1:VOLT_W] != '0)) ?
                              VOLT_MAX : div_quot[VOLT_W-1:0];
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  o_cur_ff     <= cs_ff;
                  o_chg_ff     <= chs_ff;
                  o_full_ff    <= fs_ff;
                  o_clim_ff    <= (ctot_ff[ETW-1:SUM_W] != '0) ? SUM_MAX :
                                  ctot_ff[SUM_W-1:0];
                  o_dlim_ff    <= (dtot_ff[ETW-1:SUM_W] != '0) ? SUM_MAX :
                                  dtot_ff[SUM_W-1:0];
                  o_volt_ff    <= vout_ff;
                  o_err_ff     <= err_ff;
                  count_ff     <= '0;
                  minc_ff      <= RATE_MAX;
                  mind_ff      <= RATE_MAX;
                  cs_ff        <= '0;
                  chs_ff       <= '0;
                  fs_ff        <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_pack_current         = o_cur_ff;
   assign rsp_pack_charge          = o_chg_ff;
   assign rsp_pack_full_charge     = o_full_ff;
   assign rsp_pack_charge_limit    = o_clim_ff;
   assign rsp_pack_discharge_limit = o_dlim_ff;
   assign rsp_pack_voltage         = o_volt_ff;
   assign rsp_divide_error         = o_err_ff;

`ifndef ASSERT_OFF
   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_CELLS))
      else $error("entry count beyond store depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= count_ff || state_ff == ST_IDLE || state_ff == ST_DIVC ||
      state_ff == ST_DIVD || state_ff == ST_UPD)
      else $error("walk index passed entry count");

   a_err_volt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_err_ff) |-> (o_volt_ff == '0))
      else $error("divide error with nonzero voltage");
`endif

endmodule

// File: sim/tb_top.sv
// Testbench for battery_pack_status_aggregator: cell items in, pack status out.
// Predicts each pack result in-line and checks every result field by field.
// Depends on bpsa_pkg and the RTL of the block.
module tb_top;
   import bpsa_pkg::*;

   localparam int CELLS = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [CUR_W-1:0] current;
      logic [SUM_W-1:0]        charge;
      logic [SUM_W-1:0]        full_charge;
      logic [SUM_W-1:0]        charge_limit;
      logic [SUM_W-1:0]        discharge_limit;
      logic [VOLT_W-1:0]       voltage;
      logic                    div_err;
   } pack_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_CUR_W-1:0] req_cell_current = '0;
   logic [FIELD_W-1:0] req_cell_charge = '0;
   logic [FIELD_W-1:0] req_cell_full_charge = '0;
   logic [FIELD_W-1:0] req_cell_charge_limit = '0;
   logic [FIELD_W-1:0] req_cell_discharge_limit = '0;
   logic [VOLT_W-1:0] req_cell_voltage = '0;
   logic req_last_cell = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CUR_W-1:0] rsp_pack_current;
   logic [SUM_W-1:0] rsp_pack_charge, rsp_pack_full_charge;
   logic [SUM_W-1:0] rsp_pack_charge_limit, rsp_pack_discharge_limit;
   logic [VOLT_W-1:0] rsp_pack_voltage;
   logic rsp_divide_error;

   battery_pack_status_aggregator #(.MAX_CELLS(CELLS)) uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // pack state mirror
   logic [FIELD_W-1:0] room_q[CELLS];
   logic [FIELD_W-1:0] chg_q[CELLS];
   logic [VOLT_W-1:0]  volt_q[CELLS];
   int unsigned        n_cells;
   logic [RATE_W-1:0]  min_crate, min_drate;
   longint             cur_total;
   longint unsigned    chg_total, full_total;

   pack_status_type expected_packs[$];
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  failed = 0;
   int  quiet_cycles = 0;

   function automatic logic [RATE_W-1:0] q16_rate(logic [FIELD_W-1:0] num,
                                                  logic [FIELD_W-1:0] den);
      longint unsigned q;
      if (den == 0) return '0;
      q = (longint'(num) << 16) / den;
      return (q > RATE_MAX) ? RATE_MAX : q[RATE_W-1:0];
   endfunction

   task automatic clear_pack();
      n_cells = 0;
      min_crate = RATE_MAX;
      min_drate = RATE_MAX;
      cur_total = 0;
      chg_total = 0;
      full_total = 0;
   endtask

   task automatic predict_cell(logic signed [IN_CUR_W-1:0] cur, logic [FIELD_W-1:0] chg,
                               logic [FIELD_W-1:0] full, logic [FIELD_W-1:0] clim,
                               logic [FIELD_W-1:0] dlim, logic [VOLT_W-1:0] volt,
                               logic last);
      logic [FIELD_W-1:0] room;
      logic [RATE_W-1:0] cr, dr;
      longint unsigned ce, de, ctot, dtot, cpow, dpow, cout, dout, v;
      pack_status_type p;
      if (n_cells < CELLS) begin
         room = (full > chg) ? full - chg : '0;
         cr = q16_rate(clim, room);
         dr = q16_rate(dlim, chg);
         room_q[n_cells] = room;
         chg_q[n_cells] = chg;
         volt_q[n_cells] = volt;
         n_cells++;
         if (cr < min_crate) min_crate = cr;
         if (dr < min_drate) min_drate = dr;
         cur_total += longint'(cur);
         if (cur_total > 16777215) cur_total = 16777215;
         if (cur_total < -16777216) cur_total = -16777216;
         chg_total += chg;
         if (chg_total > SUM_MAX) chg_total = SUM_MAX;
         full_total += full;
         if (full_total > SUM_MAX) full_total = SUM_MAX;
      end
      if (!last) return;
      ctot = 0; dtot = 0; cpow = 0; dpow = 0; cout = 0; dout = 0;
      for (int i = 0; i < n_cells; i++) begin
         ce = (longint'(room_q[i]) * min_crate) >> 16;
         de = (longint'(chg_q[i]) * min_drate) >> 16;
         ctot += ce;
         dtot += de;
         cpow += ce * volt_q[i];
         dpow += de * volt_q[i];
         cout += ce;
         if (cout > SUM_MAX) cout = SUM_MAX;
         dout += de;
         if (dout > SUM_MAX) dout = SUM_MAX;
      end
      p.div_err = 1'b0;
      if (ctot != 0) v = cpow / ctot;
      else if (dtot != 0) v = dpow / dtot;
      else begin
         v = 0;
         p.div_err = 1'b1;
      end
      p.voltage = (v > VOLT_MAX) ? VOLT_MAX : v[VOLT_W-1:0];
      p.current = cur_total[CUR_W-1:0];
      p.charge = chg_total[SUM_W-1:0];
      p.full_charge = full_total[SUM_W-1:0];
      p.charge_limit = cout[SUM_W-1:0];
      p.discharge_limit = dout[SUM_W-1:0];
      expected_packs = {expected_packs, p};
      clear_pack();
   endtask

   task automatic send_cell(logic signed [IN_CUR_W-1:0] cur, logic [FIELD_W-1:0] chg,
                            logic [FIELD_W-1:0] full, logic [FIELD_W-1:0] clim,
                            logic [FIELD_W-1:0] dlim, logic [VOLT_W-1:0] volt,
                            logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_current <= cur;
      req_cell_charge <= chg;
      req_cell_full_charge <= full;
      req_cell_charge_limit <= clim;
      req_cell_discharge_limit <= dlim;
      req_cell_voltage <= volt;
      req_last_cell <= last;
      do @(posedge clock); while (!req_ready);
      predict_cell(cur, chg, full, clim, dlim, volt, last);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_packs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_field();
      case ($urandom_range(5))
         0: return '0;
         1: return {FIELD_W{1'b1}};
         2: return FIELD_W'($urandom_range(255));
         3: return FIELD_W'($urandom_range(4095));
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   task automatic send_random_cell(logic last);
      logic [FIELD_W-1:0] chg, full;
      chg = rand_field();
      full = ($urandom_range(3) == 0) ? rand_field() :
             chg + FIELD_W'($urandom_range(65535));
      send_cell(IN_CUR_W'($urandom), chg, full, rand_field(), rand_field(),
                VOLT_W'($urandom), last);
   endtask

   task automatic test_directed();
      // single cell, all zeros: both totals zero
      send_cell('0, '0, '0, '0, '0, '0, 1'b1);
      // extremes of every field
      send_cell({1'b0, {20{1'b1}}}, '1, '1, '1, '1, '1, 1'b0);
      send_cell({1'b1, 20'd0}, '0, '1, '1, '1, '1, 1'b1);
      // negative room, zero divisors, rate overflow
      send_cell(-21'sd5, 20'd1000, 20'd10, 20'd500, '1, 16'd3700, 1'b0);
      send_cell(21'sd7, 20'd1, 20'd2, '1, '1, 16'd4200, 1'b1);
      // only discharge terms nonzero
      send_cell(21'sd100, 20'd5000, 20'd5000, 20'd300, 20'd2000, 16'd3600, 1'b0);
      send_cell(21'sd100, 20'd4000, 20'd3000, 20'd300, 20'd2000, 16'd3800, 1'b1);
      // overfilled store, current totals near both limits
      for (int i = 0; i < CELLS + 2; i++)
         send_cell({1'b0, {20{1'b1}}}, '1, '1, 20'd1000, 20'd1000, 16'hFFFF,
                   i == CELLS + 1);
      for (int i = 0; i < CELLS; i++)
         send_cell({1'b1, 20'd0}, 20'd100, 20'd200, 20'd50, 20'd60, 16'd3000,
                   i == CELLS - 1);
      wait_drained();
   endtask

   task automatic test_random(int packs);
      int len;
      for (int k = 0; k < packs; k++) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(CELLS + 3, CELLS + 1)
                                         : $urandom_range(CELLS, 1);
         for (int i = 0; i < len; i++) send_random_cell(i == len - 1);
         if (k == packs / 2) wait_drained();
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      pack_status_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_packs.size() == 0) begin
            $display("%0t unexpected pack result", $time);
            failed = 1;
         end else begin
            e = expected_packs.pop_front();
            if (rsp_pack_current !== e.current) begin
               $display("%0t pack_current exp %0d got %0d", $time, e.current,
                        rsp_pack_current);
               failed = 1;
            end
            if (rsp_pack_charge !== e.charge) begin
               $display("%0t pack_charge exp %0d got %0d", $time, e.charge,
                        rsp_pack_charge);
               failed = 1;
            end
            if (rsp_pack_full_charge !== e.full_charge) begin
               $display("%0t pack_full_charge exp %0d got %0d", $time, e.full_charge,
                        rsp_pack_full_charge);
               failed = 1;
            end
            if (rsp_pack_charge_limit !== e.charge_limit) begin
               $display("%0t pack_charge_limit exp %0d got %0d", $time, e.charge_limit,
                        rsp_pack_charge_limit);
               failed = 1;
            end
            if (rsp_pack_discharge_limit !== e.discharge_limit) begin
               $display("%0t pack_discharge_limit exp %0d got %0d", $time,
                        e.discharge_limit, rsp_pack_discharge_limit);
               failed = 1;
            end
            if (rsp_pack_voltage !== e.voltage) begin
               $display("%0t pack_voltage exp %0d got %0d", $time, e.voltage,
                        rsp_pack_voltage);
               failed = 1;
            end
            if (rsp_divide_error !== e.div_err) begin
               $display("%0t divide_error exp %0b got %0b", $time, e.div_err,
                        rsp_divide_error);
               failed = 1;
            end
         end
      end
   end

   initial begin
      clear_pack();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 82;
      test_directed();
      test_random(45);
      wait_drained();
      send_idle_pct = 82;
      recv_idle_pct = 33;
      test_random(45);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(45);
      wait_drained();
      repeat (1500) @(posedge clock);
      if (!failed && expected_packs.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
